@@ hw/rtl/mbdq_pkg.sv @@
// Shared types, constants and codes of the memory budget dispatch queue.
package mbdq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TAG_BITS    = 8;
  localparam int unsigned COST_BITS   = 48;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COST_BITS-1:0] LIMIT_AT_RESET = COST_BITS'(64'd512 * 64'd1024 * 64'd1024);

  typedef enum logic [1:0] {
    FN_ENQUEUE  = 2'd0,
    FN_DISPATCH = 2'd1,
    FN_COMPLETE = 2'd2,
    FN_STOP     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_WAIT   = 2'd1,
    STAT_HALTED = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [COST_BITS-1:0] cost;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    read_head;
    logic    exec_enq;
    logic    exec_grant;
    logic    exec_complete;
    logic    exec_stop;
    logic    load_out;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e func;
    logic  queue_full;
    logic  halted;
    logic  head_fits;
    logic  out_busy;
  } sts_t;

endpackage

@@ hw/rtl/mbdq_req_if.sv @@
// Request channel: one operation beat into the dispatch queue.
interface mbdq_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic [mbdq_pkg::TAG_BITS-1:0]       task_tag;
  logic [mbdq_pkg::COST_BITS-1:0]      task_cost;
  logic                                task_error;

  modport source (output valid, func, task_tag, task_cost, task_error, input ready);
  modport sink   (input valid, func, task_tag, task_cost, task_error, output ready);
endinterface

@@ hw/rtl/mbdq_rsp_if.sv @@
// Response channel: one result beat out of the dispatch queue.
interface mbdq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [mbdq_pkg::TAG_BITS-1:0]       grant_tag;
  logic [mbdq_pkg::COST_BITS-1:0]      grant_cost;
  logic [mbdq_pkg::COST_BITS-1:0]      usage_now;
  logic [mbdq_pkg::CNT_W-1:0]          queue_level;
  logic                                failure_flag;

  modport source (output valid, status, grant_tag, grant_cost, usage_now, queue_level,
                  failure_flag, input ready);
  modport sink   (input valid, status, grant_tag, grant_cost, usage_now, queue_level,
                  failure_flag, output ready);
endinterface

@@ hw/rtl/mbdq_ctrl.sv @@
// Controller state machine of the dispatch queue: sequences capture, head read and update.
module mbdq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mbdq_pkg::sts_t      sts_i,
  output mbdq_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.status = mbdq_pkg::STAT_OK;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read_head = 1'b1;
        state_d         = S_EXEC;
      end
      S_EXEC: begin
        // The update waits until the output register can take the result.
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
          case (sts_i.func)
            mbdq_pkg::FN_ENQUEUE: begin
              if (sts_i.queue_full) begin
                cmd_o.status = mbdq_pkg::STAT_FULL;
              end else begin
                cmd_o.exec_enq = 1'b1;
              end
            end
            mbdq_pkg::FN_DISPATCH: begin
              if (sts_i.halted) begin
                cmd_o.status = mbdq_pkg::STAT_HALTED;
              end else if (!sts_i.head_fits) begin
                cmd_o.status = mbdq_pkg::STAT_WAIT;
              end else begin
                cmd_o.exec_grant = 1'b1;
              end
            end
            mbdq_pkg::FN_COMPLETE: begin
              cmd_o.exec_complete = 1'b1;
            end
            mbdq_pkg::FN_STOP: begin
              cmd_o.exec_stop = 1'b1;
            end
            default: begin
              cmd_o.exec_stop = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/mbdq_dp.sv @@
// Datapath of the dispatch queue: task store, pointers, budget arithmetic and output register.
module mbdq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mbdq_pkg::cmd_t                      cmd_i,
  output mbdq_pkg::sts_t                      sts_o,
  input  logic [1:0]                          func_i,
  input  logic [mbdq_pkg::TAG_BITS-1:0]       task_tag_i,
  input  logic [mbdq_pkg::COST_BITS-1:0]      task_cost_i,
  input  logic                                task_error_i,
  input  logic                                cfg_we_i,
  input  logic [mbdq_pkg::COST_BITS-1:0]      cfg_wdata_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic [mbdq_pkg::TAG_BITS-1:0]       grant_tag_o,
  output logic [mbdq_pkg::COST_BITS-1:0]      grant_cost_o,
  output logic [mbdq_pkg::COST_BITS-1:0]      usage_now_o,
  output logic [mbdq_pkg::CNT_W-1:0]          queue_level_o,
  output logic                                failure_flag_o
);

  localparam int unsigned CB = mbdq_pkg::COST_BITS;
  localparam int unsigned PW = mbdq_pkg::PTR_W;
  localparam int unsigned CW = mbdq_pkg::CNT_W;

  mbdq_pkg::entry_t mem [mbdq_pkg::QUEUE_DEPTH];
  mbdq_pkg::entry_t head_q;

  // Captured request beat.
  mbdq_pkg::func_e              func_q;
  logic [mbdq_pkg::TAG_BITS-1:0] tag_q;
  logic [CB-1:0]                cost_q;
  logic                         err_q;

  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [CB-1:0] usage_q, usage_d, limit_q;
  logic          halt_q, halt_d, fail_q, fail_d;
  logic          out_valid_q;

  logic [1:0]                    status_q;
  logic [mbdq_pkg::TAG_BITS-1:0] grant_tag_q;
  logic [CB-1:0]                 grant_cost_q;
  logic [CB-1:0]                 usage_out_q;
  logic [CW-1:0]                 level_q;
  logic                          fail_out_q;

  logic [CB:0]   sum_wide;
  logic [CB-1:0] usage_add, usage_sub, headroom;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= mbdq_pkg::func_e'(func_i);
      tag_q  <= task_tag_i;
      cost_q <= task_cost_i;
      err_q  <= task_error_i;
    end
    if (cmd_i.exec_enq) begin
      mem[wr_ptr_q] <= '{tag: tag_q, cost: cost_q};
    end
    if (cmd_i.read_head) begin
      head_q <= mem[rd_ptr_q];
    end
  end

  always_comb begin
    sum_wide  = {1'b0, usage_q} + {1'b0, head_q.cost};
    usage_add = sum_wide[CB] ? {CB{1'b1}} : sum_wide[CB-1:0];
    usage_sub = (cost_q >= usage_q) ? '0 : usage_q - cost_q;
    headroom  = limit_q - usage_q;
  end

  always_comb begin
    sts_o.func       = func_q;
    sts_o.queue_full = (count_q == CW'(mbdq_pkg::QUEUE_DEPTH));
    sts_o.halted     = halt_q | fail_q;
    sts_o.head_fits  = (count_q != '0) &&
                       ((usage_q == '0) || ((usage_q < limit_q) && (head_q.cost <= headroom)));
    sts_o.out_busy   = out_valid_q & ~out_ready_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    usage_d  = usage_q;
    halt_d   = halt_q | cmd_i.exec_stop;
    fail_d   = fail_q | (cmd_i.exec_complete & err_q);
    if (cmd_i.exec_enq) begin
      wr_ptr_d = (wr_ptr_q == PW'(mbdq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      count_d  = count_q + CW'(1);
    end
    if (cmd_i.exec_grant) begin
      rd_ptr_d = (rd_ptr_q == PW'(mbdq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      count_d  = count_q - CW'(1);
      usage_d  = usage_add;
    end
    if (cmd_i.exec_complete) begin
      usage_d = usage_sub;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      usage_q     <= '0;
      halt_q      <= 1'b0;
      fail_q      <= 1'b0;
      limit_q     <= mbdq_pkg::LIMIT_AT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      usage_q  <= usage_d;
      halt_q   <= halt_d;
      fail_q   <= fail_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q     <= cmd_i.status;
      grant_tag_q  <= cmd_i.exec_grant ? head_q.tag : '0;
      grant_cost_q <= cmd_i.exec_grant ? head_q.cost : '0;
      usage_out_q  <= usage_d;
      level_q      <= count_d;
      fail_out_q   <= fail_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign grant_tag_o    = grant_tag_q;
  assign grant_cost_o   = grant_cost_q;
  assign usage_now_o    = usage_out_q;
  assign queue_level_o  = level_q;
  assign failure_flag_o = fail_out_q;

endmodule

@@ hw/rtl/memory_budget_dispatch_queue.sv @@
// Top level of the memory budget dispatch queue: controller, datapath and checks.
//
//   Channel   Direction  Beat carries
//   req_i     in         func, task_tag, task_cost, task_error
//   rsp_o     out        status, grant_tag, grant_cost, usage_now, queue_level, failure_flag
//   cfg       in         cfg_we_i / cfg_wdata_i write the budget limit, no handshake
//
// Each request beat passes through capture, a read of the head entry from the task
// store's single registered read port, then the budget update and result load.
// The result sits in an output register, so the next request is taken while it waits;
// a request only stalls in its update cycle if the previous result is still unclaimed.
// Reset is asynchronous and active low; it clears pointers, count, usage and flags and
// loads the budget limit with 512 MiB. The task store itself is not cleared.
module memory_budget_dispatch_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mbdq_req_if.sink                        req_i,
  mbdq_rsp_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [mbdq_pkg::COST_BITS-1:0]  cfg_wdata_i
);

  mbdq_pkg::cmd_t cmd;
  mbdq_pkg::sts_t sts;

  // The controller only decides what happens; all state but its own sequencing state lives in the datapath.
  mbdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mbdq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (req_i.func),
    .task_tag_i     (req_i.task_tag),
    .task_cost_i    (req_i.task_cost),
    .task_error_i   (req_i.task_error),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .grant_tag_o    (rsp_o.grant_tag),
    .grant_cost_o   (rsp_o.grant_cost),
    .usage_now_o    (rsp_o.usage_now),
    .queue_level_o  (rsp_o.queue_level),
    .failure_flag_o (rsp_o.failure_flag)
  );

  // A new request is never taken in the cycle straight after one was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while the previous one is still being processed");

  // The reported queue level never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.queue_level <= mbdq_pkg::CNT_W'(mbdq_pkg::QUEUE_DEPTH)))
    else $error("queue level beyond the store depth");

  // A full rejection is only reported when the queue really is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == mbdq_pkg::STAT_FULL)) |->
      (rsp_o.queue_level == mbdq_pkg::CNT_W'(mbdq_pkg::QUEUE_DEPTH)))
    else $error("queue full reported with room left");

  // A refused result (any status but OK) carries no tag and no cost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != mbdq_pkg::STAT_OK)) |->
      ((rsp_o.grant_tag == '0) && (rsp_o.grant_cost == '0)))
    else $error("grant fields set on a refused beat");

endmodule

@@ verif/memory_budget_dispatch_queue_test.sv @@
// Self-checking testbench for the memory budget dispatch queue.
`timescale 1ns / 100ps

module memory_budget_dispatch_queue_test;
  import mbdq_pkg::*;

  localparam int unsigned PRESSURE_HOLD   = 64;
  localparam int unsigned WATCHDOG_CYCLES = 1000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam logic [COST_BITS-1:0] COST_MAX = '1;

  // Tracks the queue, the budget and the sticky flags as the block should see them.
  // Each accepted request beat yields exactly one expected result beat, held in
  // order until the matching response beat turns up.
  class dispatch_budget_tracker;
    typedef struct packed {
      status_e              status;
      logic [TAG_BITS-1:0]  tag;
      logic [COST_BITS-1:0] cost;
      logic [COST_BITS-1:0] usage;
      logic [CNT_W-1:0]     level;
      logic                 failed;
    } outcome_t;

    logic [TAG_BITS-1:0]  tag_store [QUEUE_DEPTH];
    logic [COST_BITS-1:0] cost_store[QUEUE_DEPTH];
    int unsigned          rd_ptr;
    int unsigned          wr_ptr;
    int unsigned          waiting;
    logic [COST_BITS-1:0] usage;
    logic [COST_BITS-1:0] limit;
    bit                   halted;
    bit                   failed;
    outcome_t             awaited_results[$];
    int unsigned          mismatch_count;

    function new();
      rd_ptr         = 0;
      wr_ptr         = 0;
      waiting        = 0;
      usage          = '0;
      limit          = LIMIT_AT_RESET;
      halted         = 1'b0;
      failed         = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_limit(logic [COST_BITS-1:0] value);
      limit = value;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function void note_request(func_e func, logic [TAG_BITS-1:0] tag,
                               logic [COST_BITS-1:0] cost, logic err);
      outcome_t             res;
      logic [COST_BITS-1:0] head_cost;
      bit                   fits;
      res        = '0;
      res.status = STAT_OK;
      case (func)
        FN_ENQUEUE: begin
          if (waiting >= QUEUE_DEPTH) begin
            res.status = STAT_FULL;
          end else begin
            tag_store[wr_ptr]  = tag;
            cost_store[wr_ptr] = cost;
            wr_ptr             = (wr_ptr + 1) % QUEUE_DEPTH;
            waiting++;
          end
        end
        FN_DISPATCH: begin
          head_cost = cost_store[rd_ptr];
          // An idle budget always admits the head; otherwise it must fit in what is left.
          fits = (waiting != 0) &&
                 ((usage == '0) || ((usage < limit) && (head_cost <= limit - usage)));
          if (halted || failed) begin
            res.status = STAT_HALTED;
          end else if (!fits) begin
            res.status = STAT_WAIT;
          end else begin
            res.tag  = tag_store[rd_ptr];
            res.cost = head_cost;
            rd_ptr   = (rd_ptr + 1) % QUEUE_DEPTH;
            waiting--;
            if (head_cost > COST_MAX - usage) begin
              usage = COST_MAX;
            end else begin
              usage = usage + head_cost;
            end
          end
        end
        FN_COMPLETE: begin
          usage = (cost >= usage) ? '0 : usage - cost;
          if (err) begin
            failed = 1'b1;
          end
        end
        default: begin
          halted = 1'b1;
        end
      endcase
      res.usage  = usage;
      res.level  = CNT_W'(waiting);
      res.failed = failed;
      awaited_results.push_back(res);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(logic [1:0] status, logic [TAG_BITS-1:0] tag,
                               logic [COST_BITS-1:0] cost, logic [COST_BITS-1:0] use_now,
                               logic [CNT_W-1:0] level, logic flag);
      outcome_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat arrived with no request outstanding");
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        compare("status", 64'(want.status), 64'(status));
        compare("grant_tag", 64'(want.tag), 64'(tag));
        compare("grant_cost", 64'(want.cost), 64'(cost));
        compare("usage_now", 64'(want.usage), 64'(use_now));
        compare("queue_level", 64'(want.level), 64'(level));
        compare("failure_flag", 64'(want.failed), 64'(flag));
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [COST_BITS-1:0] cfg_wdata_i;

  mbdq_req_if req_if ();
  mbdq_rsp_if rsp_if ();

  memory_budget_dispatch_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  dispatch_budget_tracker tracker = new();

  // Knobs shared between the request side and the response side.
  logic [COST_BITS-1:0] cur_limit = LIMIT_AT_RESET;
  bit                   quiet = 1'b0;        // no idling at all in the closing part
  bit                   sender_idle = 1'b1;
  bit                   pressure_req = 1'b0;
  int unsigned          enq_weight = 40;

  always #6 clk_i = ~clk_i;

  // Response side: checks every accepted beat against the oldest expectation, and
  // drops ready in random bursts. A pressure request holds ready low for a long
  // stretch so that the block's pipeline backs up into the request channel.
  initial begin : response_side
    int unsigned hold;
    int unsigned cyc;
    bit          rcv_idle;
    hold           = 0;
    cyc            = 0;
    rcv_idle       = 1'b1;
    rsp_if.ready   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        tracker.check_result(rsp_if.status, rsp_if.grant_tag, rsp_if.grant_cost,
                             rsp_if.usage_now, rsp_if.queue_level, rsp_if.failure_flag);
      end
      cyc++;
      if (cyc % 64 == 0) begin
        rcv_idle = ($urandom_range(0, 2) != 0);
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (pressure_req) begin
        pressure_req = 1'b0;
        hold         = PRESSURE_HOLD - 1;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && rcv_idle && $urandom_range(0, 5) == 0) begin
        hold         = $urandom_range(0, 11);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int unsigned still;
    still = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        still = 0;
      end else begin
        still++;
      end
      if (still >= WATCHDOG_CYCLES) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [COST_BITS-1:0] rand_cost48();
    return COST_BITS'({$urandom, $urandom});
  endfunction

  // Costs cluster around fractions of the current budget so that grants, waits and
  // exact fits all happen; the extremes and wholly random values are mixed in.
  function automatic logic [COST_BITS-1:0] pick_cost();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return '0;
      1:       return COST_MAX;
      2:       return rand_cost48();
      3:       return COST_BITS'($urandom_range(1, 255));
      default: return cur_limit / $urandom_range(1, 6) + COST_BITS'($urandom_range(0, 3));
    endcase
  endfunction

  // Offers one request beat and returns at the edge where it is accepted. Valid is
  // left high so that the next beat can follow without a bubble.
  task automatic send_item(func_e func, logic [TAG_BITS-1:0] tag,
                           logic [COST_BITS-1:0] cost, logic err);
    if (!quiet && sender_idle && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= func;
    req_if.task_tag   <= tag;
    req_if.task_cost  <= cost;
    req_if.task_error <= err;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    tracker.note_request(func, tag, cost, err);
  endtask

  // Random traffic. The enqueue share drifts so that the queue both fills to the
  // brim and drains dry. Stop and failed completions are sticky until reset, so
  // they only appear in the closing part of the run.
  task automatic run_random(int unsigned count, bit allow_end);
    int unsigned pick;
    func_e       func;
    logic        err;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 20 == 0) begin
        enq_weight  = $urandom_range(15, 75);
        sender_idle = ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 99);
      err  = 1'b0;
      if (allow_end && pick < 4) begin
        func = FN_STOP;
      end else if (pick < enq_weight) begin
        func = FN_ENQUEUE;
      end else if (pick < enq_weight + (100 - enq_weight) * 3 / 5) begin
        func = FN_DISPATCH;
      end else begin
        func = FN_COMPLETE;
        err  = allow_end && ($urandom_range(0, 3) == 0);
      end
      send_item(func, TAG_BITS'($urandom_range(0, 255)), pick_cost(), err);
    end
  endtask

  // Lowers valid and waits until every expected result beat has been claimed, which
  // leaves the block idle because every request produces a result.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [COST_BITS-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_limit(value);
    cur_limit = value;
  endtask

  initial begin : request_side
    req_if.valid      = 1'b0;
    req_if.func       = FN_ENQUEUE;
    req_if.task_tag   = '0;
    req_if.task_cost  = '0;
    req_if.task_error = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    rst_ni            = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening with the limit as it comes out of reset.
    send_item(FN_DISPATCH, 8'h00, '0, 1'b0);            // empty queue: must wait
    send_item(FN_ENQUEUE, 8'h00, '0, 1'b0);
    send_item(FN_ENQUEUE, 8'hff, COST_MAX, 1'b0);
    send_item(FN_ENQUEUE, 8'h5a, 48'd1, 1'b0);
    send_item(FN_DISPATCH, 8'h00, '0, 1'b0);            // zero-cost grant
    send_item(FN_DISPATCH, 8'h00, '0, 1'b0);            // nothing in use: huge task granted
    send_item(FN_DISPATCH, 8'h00, '0, 1'b0);            // usage over the limit: wait
    send_item(FN_COMPLETE, 8'h00, 48'd1, 1'b0);
    send_item(FN_COMPLETE, 8'h00, COST_MAX, 1'b0);      // more than in use: clamps to zero
    send_item(FN_ENQUEUE, 8'ha5, LIMIT_AT_RESET, 1'b0);
    send_item(FN_DISPATCH, 8'h00, '0, 1'b0);
    send_item(FN_DISPATCH, 8'h00, '0, 1'b0);            // head does not fit the remainder
    send_item(FN_COMPLETE, 8'h00, 48'd1, 1'b0);
    send_item(FN_DISPATCH, 8'h00, '0, 1'b0);
    send_item(FN_COMPLETE, 8'h00, LIMIT_AT_RESET / 2, 1'b0);
    send_item(FN_ENQUEUE, 8'h33, LIMIT_AT_RESET / 2, 1'b0);
    send_item(FN_DISPATCH, 8'h00, '0, 1'b0);            // fits exactly
    send_item(FN_COMPLETE, 8'h00, '0, 1'b0);
    run_random(110, 1'b0);
    drain();

    // A tight budget, with one long receiver hold-off while requests keep coming.
    write_limit(COST_BITS'($urandom_range(64, 4096)));
    pressure_req = 1'b1;
    run_random(110, 1'b0);
    drain();

    // A zero budget only admits work while nothing is in use.
    write_limit('0);
    run_random(90, 1'b0);
    drain();

    write_limit(COST_MAX);
    run_random(90, 1'b0);
    drain();

    write_limit(rand_cost48());
    run_random(90, 1'b0);
    drain();

    // Closing part: no idling, then stop and failure, after which dispatch is refused.
    quiet = 1'b1;
    write_limit(LIMIT_AT_RESET);
    send_item(FN_ENQUEUE, 8'h11, 48'd100, 1'b0);
    send_item(FN_STOP, 8'h00, '0, 1'b0);
    send_item(FN_DISPATCH, 8'h00, '0, 1'b0);            // halted by stop
    send_item(FN_STOP, 8'h00, '0, 1'b0);                // a second stop changes nothing
    send_item(FN_COMPLETE, 8'h00, '0, 1'b1);            // raises the failure flag
    send_item(FN_ENQUEUE, 8'h22, 48'd7, 1'b0);          // still accepted
    send_item(FN_DISPATCH, 8'h00, '0, 1'b0);
    run_random(70, 1'b1);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
